// ===== design/qvp_pkg.sv =====
// ----------------------------------------------------------------------------
// qvp_pkg: shared definitions for the quad vertex projection core
// Sequencer states, register indexes, multiply steps, 24-bit limits, CORDIC
// constants and the arctangent table used by the shared arithmetic datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package qvp_pkg;

   // CORDIC iteration count, limited by the depth of the arctangent table
   localparam int CORDIC_STEPS = 16;
   localparam int ATAN_DEPTH   = 24;
   localparam int CORDIC_ITERS = (CORDIC_STEPS < ATAN_DEPTH) ? CORDIC_STEPS : ATAN_DEPTH;

   // corners per quad
   localparam int CORNERS = 4;

   // CORDIC start gain, scale 2^30
   localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;

   // 24-bit saturation limits
   localparam logic signed [23:0] MAX24 = 24'sh7FFFFF;
   localparam logic signed [23:0] MIN24 = 24'sh800000;

   // configuration register indexes
   localparam logic [3:0] REG_FOCAL = 4'd0;
   localparam logic [3:0] REG_SKEW  = 4'd1;
   localparam logic [3:0] REG_PX    = 4'd2;
   localparam logic [3:0] REG_PY    = 4'd3;
   localparam logic [3:0] REG_CAMX  = 4'd4;
   localparam logic [3:0] REG_CAMY  = 4'd5;
   localparam logic [3:0] REG_CAMZ  = 4'd6;
   localparam logic [3:0] REG_YAW   = 4'd7;

   // multiply schedule steps
   localparam logic [3:0] M_CDX  = 4'd0;
   localparam logic [3:0] M_SDZ  = 4'd1;
   localparam logic [3:0] M_CDZ  = 4'd2;
   localparam logic [3:0] M_SDX  = 4'd3;
   localparam logic [3:0] M_FRX  = 4'd4;
   localparam logic [3:0] M_KDY  = 4'd5;
   localparam logic [3:0] M_PXRZ = 4'd6;
   localparam logic [3:0] M_FDY  = 4'd7;
   localparam logic [3:0] M_PYRZ = 4'd8;
   localparam logic [3:0] M_EXX  = 4'd9;
   localparam logic [3:0] M_EYY  = 4'd10;
   localparam logic [3:0] M_EZZ  = 4'd11;

   typedef enum logic [2:0] {
      S_IDLE,
      S_TRIG,
      S_TFIN,
      S_MUL,
      S_DIV,
      S_SUM,
      S_SQRT,
      S_OUT
   } state_type;

   // arctangent table, units of 2^-32 turn
   function automatic logic [31:0] atan_entry(input logic [4:0] idx);
      logic [31:0] val;
      case (idx)
         5'd0:    val = 32'h20000000;
         5'd1:    val = 32'h12E4051E;
         5'd2:    val = 32'h09FB385B;
         5'd3:    val = 32'h051111D4;
         5'd4:    val = 32'h028B0D43;
         5'd5:    val = 32'h0145D7E1;
         5'd6:    val = 32'h00A2F61E;
         5'd7:    val = 32'h00517C55;
         5'd8:    val = 32'h0028BE53;
         5'd9:    val = 32'h00145F2F;
         5'd10:   val = 32'h000A2F98;
         5'd11:   val = 32'h000517CC;
         5'd12:   val = 32'h00028BE6;
         5'd13:   val = 32'h000145F3;
         5'd14:   val = 32'h0000A2FA;
         5'd15:   val = 32'h0000517D;
         5'd16:   val = 32'h000028BE;
         5'd17:   val = 32'h0000145F;
         5'd18:   val = 32'h00000A30;
         5'd19:   val = 32'h00000518;
         5'd20:   val = 32'h0000028C;
         5'd21:   val = 32'h00000146;
         5'd22:   val = 32'h000000A3;
         5'd23:   val = 32'h00000051;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

endpackage

`default_nettype wire

// ===== design/quad_vertex_projection_core.sv =====
// Vertex beat to result beat: 9 products on the shared multiplier (multiply phase,
// accumulate phase), the bit-serial divider for x then y, sum, output load; CORDIC
// first after reset or a yaw write, distance products and square root before the
// output load on a quad's fourth corner. The next vertex is taken once the result
// sits in the output register, which holds it until the sink takes the beat.
// Reset: synchronous, active high; registers return to defaults, sums clear.
// ----------------------------------------------------------------------------
// quad_vertex_projection_core: pinhole projection of quad corners
// Rotates each vertex about the camera by yaw (CORDIC, cached), applies the
// intrinsics, divides by depth and gives the quad centroid distance.
// ----------------------------------------------------------------------------
`default_nettype none

module quad_vertex_projection_core
   import qvp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   // configuration write channel
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [23:0] csr_data,
   // vertex input
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [71:0] req_tdata,   // vertex_x, vertex_y, vertex_z
   // projected result
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [71:0]      rsp_tdata,   // screen_x, screen_y, zero_depth, quad_distance, pad
   output logic             rsp_tlast    // quad_last
);

   // configuration registers
   logic        [23:0] focal_ff, px_ff, py_ff;
   logic signed [23:0] skew_ff, camx_ff, camy_ff, camz_ff;
   logic        [15:0] yaw_ff;

   state_type state_ff, state_in;

   // trig cache and CORDIC
   logic               trig_ready_ff;
   logic signed [16:0] cos_ff, sin_ff;
   logic signed [33:0] cx_ff, cy_ff, cz_ff;
   logic               flip_ff;
   logic        [4:0]  iter_ff;

   // vertex relative to camera
   logic signed [24:0] dx_ff, dy_ff, dz_ff;

   // shared multiplier
   logic        [3:0]  mstep_ff;
   logic               phase_ff;
   logic signed [28:0] mul_a, mul_b;
   logic signed [57:0] prod_ff;
   logic signed [59:0] acc_ff, acc_new;
   logic signed [27:0] rx_ff, rz_ff;
   logic signed [59:0] numx_ff, numy_ff;

   // divider
   logic               div_sel_ff;
   logic        [5:0]  div_cnt_ff;
   logic        [53:0] div_q_ff, div_q_next;
   logic        [27:0] div_rem_ff, div_trial;
   logic               div_ge;
   logic        [26:0] div_d;
   logic               div_neg_ff;
   logic signed [23:0] sx_ff, sy_ff, div_res;

   // centroid
   logic        [1:0]  corner_ff;
   logic signed [25:0] sum_x_ff, sum_y_ff, sum_z_ff;
   logic signed [25:0] sum_x_new, sum_y_new, sum_z_new;
   logic signed [24:0] ex_ff, ey_ff, ez_ff;
   logic               last_ff;

   // square root
   logic        [49:0] sq_n_ff, sq_r_ff, sq_bit_ff, sq_try, sq_r_next;
   logic        [4:0]  sq_cnt_ff;
   logic        [16:0] dist_ff;

   // output register
   logic               out_valid_ff, out_load;
   logic signed [23:0] out_sx_ff, out_sy_ff;
   logic               out_zero_ff, out_last_ff;
   logic        [16:0] out_dist_ff;

   logic               req_fire;

   // helpers
   function automatic logic signed [16:0] sat17(input logic signed [33:0] v);
      logic signed [16:0] r;
      if (v > 34'sd65535)       r = 17'sd65535;
      else if (v < -34'sd65536) r = -17'sd65536;
      else                      r = v[16:0];
      return r;
   endfunction

   function automatic logic signed [23:0] sat24(input logic signed [28:0] v);
      logic signed [23:0] r;
      if (v > 29'sd8388607)       r = MAX24;
      else if (v < -29'sd8388608) r = MIN24;
      else                        r = v[23:0];
      return r;
   endfunction

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff <= 24'd76800;
         skew_ff  <= '0;
         px_ff    <= 24'd81920;
         py_ff    <= 24'd65536;
         camx_ff  <= '0;
         camy_ff  <= '0;
         camz_ff  <= '0;
         yaw_ff   <= '0;
      end else if (csr_valid) begin
         case (csr_index)
            REG_FOCAL: focal_ff <= csr_data;
            REG_SKEW:  skew_ff  <= csr_data;
            REG_PX:    px_ff    <= csr_data;
            REG_PY:    py_ff    <= csr_data;
            REG_CAMX:  camx_ff  <= csr_data;
            REG_CAMY:  camy_ff  <= csr_data;
            REG_CAMZ:  camz_ff  <= csr_data;
            REG_YAW:   yaw_ff   <= csr_data[15:0];
            default: begin
            end
         endcase
      end
   end

   // multiplier operand select
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (mstep_ff)
         M_CDX:  begin mul_a = 29'(cos_ff);   mul_b = 29'(dx_ff); end
         M_SDZ:  begin mul_a = 29'(sin_ff);   mul_b = 29'(dz_ff); end
         M_CDZ:  begin mul_a = 29'(cos_ff);   mul_b = 29'(dz_ff); end
         M_SDX:  begin mul_a = 29'(sin_ff);   mul_b = 29'(dx_ff); end
         M_FRX:  begin mul_a = $signed({5'd0, focal_ff}); mul_b = 29'(rx_ff); end
         M_KDY:  begin mul_a = 29'(skew_ff);  mul_b = 29'(dy_ff); end
         M_PXRZ: begin mul_a = $signed({5'd0, px_ff});    mul_b = 29'(rz_ff); end
         M_FDY:  begin mul_a = $signed({5'd0, focal_ff}); mul_b = 29'(dy_ff); end
         M_PYRZ: begin mul_a = $signed({5'd0, py_ff});    mul_b = 29'(rz_ff); end
         M_EXX:  begin mul_a = 29'(ex_ff);    mul_b = 29'(ex_ff); end
         M_EYY:  begin mul_a = 29'(ey_ff);    mul_b = 29'(ey_ff); end
         M_EZZ:  begin mul_a = 29'(ez_ff);    mul_b = 29'(ez_ff); end
         default: begin
         end
      endcase
   end

   // accumulate: load on the first product of each sum, subtract for depth
   always_comb begin
      case (mstep_ff)
         M_CDX, M_CDZ, M_FRX, M_FDY, M_EXX: acc_new = 60'(prod_ff);
         M_SDX:   acc_new = acc_ff - 60'(prod_ff);
         default: acc_new = acc_ff + 60'(prod_ff);
      endcase
   end

   // divider step on magnitudes
   always_comb begin
      div_d      = rz_ff[27] ? 27'(-rz_ff) : rz_ff[26:0];
      div_trial  = {div_rem_ff[26:0], div_q_ff[53]};
      div_ge     = (div_trial >= {1'b0, div_d});
      div_q_next = {div_q_ff[52:0], div_ge};
   end

   // signed, saturated quotient; zero depth follows numerator sign
   always_comb begin
      logic signed [59:0] num;
      num = div_sel_ff ? numy_ff : numx_ff;
      if (rz_ff == '0) begin
         if (num[59])          div_res = MIN24;
         else if (num != '0)   div_res = MAX24;
         else                  div_res = '0;
      end else if (div_neg_ff) begin
         if (div_q_next > 54'd8388608) div_res = MIN24;
         else                          div_res = 24'(-$signed({1'b0, div_q_next[23:0]}));
      end else begin
         if (div_q_next > 54'd8388607) div_res = MAX24;
         else                          div_res = div_q_next[23:0];
      end
   end

   // centroid sums with rotated world coordinates
   always_comb begin
      sum_x_new = sum_x_ff + 26'(sat24(29'(camx_ff) + 29'(rx_ff)));
      sum_y_new = sum_y_ff + 26'(sat24(29'(camy_ff) + 29'(dy_ff)));
      sum_z_new = sum_z_ff + 26'(sat24(29'(camz_ff) + 29'(rz_ff)));
   end

   // square root step
   always_comb begin
      sq_try    = sq_r_ff + sq_bit_ff;
      sq_r_next = (sq_n_ff >= sq_try) ? ((sq_r_ff >> 1) + sq_bit_ff) : (sq_r_ff >> 1);
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      out_load = 1'b0;
      case (state_ff)
         S_IDLE: if (req_fire) state_in = trig_ready_ff ? S_MUL : S_TRIG;
         S_TRIG: if (iter_ff == 5'(CORDIC_ITERS - 1)) state_in = S_TFIN;
         S_TFIN: state_in = S_MUL;
         S_MUL: begin
            if (phase_ff && mstep_ff == M_PYRZ) state_in = S_DIV;
            else if (phase_ff && mstep_ff == M_EZZ) state_in = S_SQRT;
         end
         S_DIV:  if (div_cnt_ff == 6'd53 && div_sel_ff) state_in = S_SUM;
         S_SUM:  state_in = (corner_ff == 2'(CORNERS - 1)) ? S_MUL : S_OUT;
         S_SQRT: if (sq_cnt_ff == 5'd24) state_in = S_OUT;
         S_OUT: begin
            if (!out_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_IDLE;
      else       state_ff <= state_in;
   end

   // control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         trig_ready_ff <= 1'b0;
         corner_ff     <= '0;
         sum_x_ff      <= '0;
         sum_y_ff      <= '0;
         sum_z_ff      <= '0;
         cos_ff        <= '0;
         sin_ff        <= '0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_index == REG_YAW) trig_ready_ff <= 1'b0;
         else if (state_ff == S_TFIN)           trig_ready_ff <= 1'b1;

         if (state_ff == S_TFIN) begin
            logic signed [16:0] c, s;
            c = sat17((cx_ff + 34'sd16384) >>> 15);
            s = sat17((cy_ff + 34'sd16384) >>> 15);
            if (flip_ff) begin
               c = (c == -17'sd65536) ? 17'sd65535 : -c;
               s = (s == -17'sd65536) ? 17'sd65535 : -s;
            end
            cos_ff <= c;
            sin_ff <= s;
         end

         if (state_ff == S_SUM) begin
            if (corner_ff == 2'(CORNERS - 1)) begin
               corner_ff <= '0;
               sum_x_ff  <= '0;
               sum_y_ff  <= '0;
               sum_z_ff  <= '0;
            end else begin
               corner_ff <= corner_ff + 2'd1;
               sum_x_ff  <= sum_x_new;
               sum_y_ff  <= sum_y_new;
               sum_z_ff  <= sum_z_new;
            end
         end

         if (out_load)        out_valid_ff <= 1'b1;
         else if (rsp_tready) out_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               logic signed [17:0] za;
               za = $signed({2'b00, yaw_ff});
               dx_ff <= 25'($signed(req_tdata[23:0]))  - 25'(camx_ff);
               dy_ff <= 25'($signed(req_tdata[47:24])) - 25'(camy_ff);
               dz_ff <= 25'($signed(req_tdata[71:48])) - 25'(camz_ff);
               flip_ff <= 1'b0;
               if (yaw_ff inside {[16'd16384:16'd49151]}) begin
                  flip_ff <= 1'b1;
                  za = za - 18'sd32768;
               end else if (yaw_ff inside {[16'd49152:16'hFFFF]}) begin
                  za = za - 18'sd65536;
               end
               cz_ff    <= {za, 16'd0};
               cx_ff    <= CORDIC_GAIN;
               cy_ff    <= '0;
               iter_ff  <= '0;
               mstep_ff <= M_CDX;
               phase_ff <= 1'b0;
            end
         end
         S_TRIG: begin
            logic signed [33:0] xs, ys;
            logic        [33:0] at;
            xs = cx_ff >>> iter_ff;
            ys = cy_ff >>> iter_ff;
            at = {2'b00, atan_entry(iter_ff)};
            if (!cz_ff[33]) begin
               cx_ff <= cx_ff - ys;
               cy_ff <= cy_ff + xs;
               cz_ff <= cz_ff - $signed(at);
            end else begin
               cx_ff <= cx_ff + ys;
               cy_ff <= cy_ff - xs;
               cz_ff <= cz_ff + $signed(at);
            end
            iter_ff <= iter_ff + 5'd1;
         end
         S_MUL: begin
            phase_ff <= ~phase_ff;
            if (!phase_ff) begin
               prod_ff <= mul_a * mul_b;
            end else begin
               acc_ff   <= acc_new;
               mstep_ff <= mstep_ff + 4'd1;
               case (mstep_ff)
                  M_SDZ:  rx_ff   <= 28'((acc_new + 60'sd16384) >>> 15);
                  M_SDX:  rz_ff   <= 28'((acc_new + 60'sd16384) >>> 15);
                  M_PXRZ: numx_ff <= acc_new;
                  M_PYRZ: begin
                     numy_ff    <= acc_new;
                     div_sel_ff <= 1'b0;
                     div_cnt_ff <= '0;
                     div_rem_ff <= '0;
                     div_q_ff   <= numx_ff[59] ? 54'(-numx_ff) : numx_ff[53:0];
                     div_neg_ff <= numx_ff[59] ^ rz_ff[27];
                  end
                  M_EZZ: begin
                     sq_n_ff   <= acc_new[49:0];
                     sq_r_ff   <= '0;
                     sq_bit_ff <= 50'd1 << 48;
                     sq_cnt_ff <= '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_DIV: begin
            if (div_cnt_ff == 6'd53) begin
               if (!div_sel_ff) begin
                  sx_ff      <= div_res;
                  div_sel_ff <= 1'b1;
                  div_cnt_ff <= '0;
                  div_rem_ff <= '0;
                  div_q_ff   <= numy_ff[59] ? 54'(-numy_ff) : numy_ff[53:0];
                  div_neg_ff <= numy_ff[59] ^ rz_ff[27];
               end else begin
                  sy_ff <= div_res;
               end
            end else begin
               div_cnt_ff <= div_cnt_ff + 6'd1;
               div_rem_ff <= div_ge ? (div_trial - {1'b0, div_d}) : div_trial;
               div_q_ff   <= div_q_next;
            end
         end
         S_SUM: begin
            ex_ff    <= 25'(sum_x_new >>> 2) - 25'(camx_ff);
            ey_ff    <= 25'(sum_y_new >>> 2) - 25'(camy_ff);
            ez_ff    <= 25'(sum_z_new >>> 2) - 25'(camz_ff);
            last_ff  <= (corner_ff == 2'(CORNERS - 1));
            dist_ff  <= '0;
            mstep_ff <= M_EXX;
            phase_ff <= 1'b0;
         end
         S_SQRT: begin
            if (sq_n_ff >= sq_try) sq_n_ff <= sq_n_ff - sq_try;
            sq_r_ff   <= sq_r_next;
            sq_bit_ff <= sq_bit_ff >> 2;
            sq_cnt_ff <= sq_cnt_ff + 5'd1;
            if (sq_cnt_ff == 5'd24) dist_ff <= sq_r_next[24:8];
         end
         default: begin
         end
      endcase

      // output register load
      if (out_load) begin
         out_sx_ff   <= sx_ff;
         out_sy_ff   <= sy_ff;
         out_zero_ff <= (rz_ff == '0);
         out_dist_ff <= dist_ff;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {6'd0, out_dist_ff, out_zero_ff, out_sy_ff, out_sx_ff};
   assign rsp_tlast  = out_last_ff;

   // checks
   a_trig_before_mul: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_MUL) |-> trig_ready_ff)
      else $error("products started without valid sine and cosine");

   a_count_clear_sqrt: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SQRT) |-> (corner_ff == 2'd0 && sum_x_ff == '0))
      else $error("quad state not cleared before distance");

   a_zero_depth_sat: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[48]) |->
      (rsp_tdata[23:0] == MAX24 || rsp_tdata[23:0] == MIN24 || rsp_tdata[23:0] == 24'd0))
      else $error("zero depth result not saturated");

   a_dist_only_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tlast) |-> (rsp_tdata[65:49] == 17'd0))
      else $error("distance given on a corner that is not last");

endmodule

`default_nettype wire

// ===== tb/qvp_checker.sv =====
// ----------------------------------------------------------------------------
// qvp_checker: result checker for the quad vertex projection core
// Watches the configuration, vertex and result channels, keeps its own copy
// of the registers and quad state, predicts each projected corner and
// compares every result beat with the oldest prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module qvp_checker
   import qvp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_valid,
   input  wire logic        csr_ready,
   input  wire logic [3:0]  csr_index,
   input  wire logic [23:0] csr_data,
   input  wire logic        req_tvalid,
   input  wire logic        req_tready,
   input  wire logic [71:0] req_tdata,
   input  wire logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   input  wire logic [71:0] rsp_tdata,
   input  wire logic        rsp_tlast,
   output int               error_count,
   output int               pending_count
);

   typedef struct packed {
      logic [23:0] screen_x;
      logic [23:0] screen_y;
      logic        zero_depth;
      logic [16:0] quad_distance;
      logic        quad_last;
   } projection_type;

   projection_type projection_q[$];

   // shadow registers and quad state
   longint focal, skew, prin_x, prin_y, cam_x, cam_y, cam_z;
   longint yaw;
   longint acc_x, acc_y, acc_z, cos_v, sin_v;
   int     corner;
   bit     trig_valid;

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint clamp(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
   endfunction

   function automatic longint sign24(logic [23:0] v);
      return longint'($signed(v));
   endfunction

   function automatic logic [31:0] atan_tab(int i);
      logic [31:0] t [0:23];
      t = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
            32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
            32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2FA,
            32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
            32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
      return t[i];
   endfunction

   // CORDIC sine and cosine of the yaw, scale 2^15
   task automatic compute_trig();
      longint a, z, x, y, xs, ys, c, s;
      bit     flip;
      a = yaw;
      flip = 0;
      x = 64'sh26DD3B6A;
      y = 0;
      if (a >= 16384 && a < 49152) begin
         flip = 1;
         z = a - 32768;
      end else if (a >= 49152) begin
         z = a - 65536;
      end else begin
         z = a;
      end
      z = z * 65536;
      for (int i = 0; i < CORDIC_ITERS; i++) begin
         xs = floor_shift(x, i);
         ys = floor_shift(y, i);
         if (z >= 0) begin
            x = x - ys; y = y + xs; z = z - longint'(atan_tab(i));
         end else begin
            x = x + ys; y = y - xs; z = z + longint'(atan_tab(i));
         end
      end
      c = clamp(floor_shift(x + 16384, 15), -65536, 65535);
      s = clamp(floor_shift(y + 16384, 15), -65536, 65535);
      if (flip) begin
         c = clamp(-c, -65536, 65535);
         s = clamp(-s, -65536, 65535);
      end
      cos_v = c;
      sin_v = s;
      trig_valid = 1;
   endtask

   function automatic longint int_sqrt(longint unsigned n);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= r + b) begin
            n = n - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return longint'(r);
   endfunction

   function automatic longint divide_depth(longint num, longint z);
      if (z == 0) return num > 0 ? 8388607 : (num < 0 ? -8388608 : 0);
      return clamp(num / z, -8388608, 8388607);
   endfunction

   // one projected corner from one vertex beat
   task automatic project_corner(logic [71:0] data);
      longint dx, dy, dz, rx, rz, nx, ny, ex, ey, ez;
      longint unsigned sq;
      projection_type p;
      dx = sign24(data[23:0]) - cam_x;
      dy = sign24(data[47:24]) - cam_y;
      dz = sign24(data[71:48]) - cam_z;
      if (!trig_valid) compute_trig();
      rx = floor_shift(cos_v * dx + sin_v * dz + 16384, 15);
      rz = floor_shift(cos_v * dz - sin_v * dx + 16384, 15);
      nx = focal * rx + skew * dy + prin_x * rz;
      ny = focal * dy + prin_y * rz;
      p.screen_x = 24'(divide_depth(nx, rz));
      p.screen_y = 24'(divide_depth(ny, rz));
      p.zero_depth = (rz == 0);
      p.quad_distance = '0;
      p.quad_last = 0;
      acc_x += clamp(cam_x + rx, -8388608, 8388607);
      acc_y += clamp(cam_y + dy, -8388608, 8388607);
      acc_z += clamp(cam_z + rz, -8388608, 8388607);
      if (corner >= CORNERS - 1) begin
         ex = floor_shift(acc_x, 2) - cam_x;
         ey = floor_shift(acc_y, 2) - cam_y;
         ez = floor_shift(acc_z, 2) - cam_z;
         sq = longint'(ex * ex) + longint'(ey * ey) + longint'(ez * ez);
         p.quad_distance = 17'(int_sqrt(sq) >> 8);
         p.quad_last = 1;
         corner = 0;
         acc_x = 0; acc_y = 0; acc_z = 0;
      end else begin
         corner++;
      end
      projection_q.push_back(p);
   endtask

   always @(posedge clock) begin
      projection_type got, want;
      if (reset) begin
         focal = 76800; skew = 0; prin_x = 81920; prin_y = 65536;
         cam_x = 0; cam_y = 0; cam_z = 0; yaw = 0;
         corner = 0; acc_x = 0; acc_y = 0; acc_z = 0;
         cos_v = 0; sin_v = 0; trig_valid = 0;
         error_count <= 0;
         projection_q.delete();
      end else begin
         // register writes
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_FOCAL: focal = csr_data;
               REG_SKEW:  skew = sign24(csr_data);
               REG_PX:    prin_x = csr_data;
               REG_PY:    prin_y = csr_data;
               REG_CAMX:  cam_x = sign24(csr_data);
               REG_CAMY:  cam_y = sign24(csr_data);
               REG_CAMZ:  cam_z = sign24(csr_data);
               REG_YAW: begin
                  yaw = csr_data[15:0];
                  trig_valid = 0;
               end
               default: ;
            endcase
         end
         // result beat compare
         if (rsp_tvalid && rsp_tready) begin
            got.screen_x = rsp_tdata[23:0];
            got.screen_y = rsp_tdata[47:24];
            got.zero_depth = rsp_tdata[48];
            got.quad_distance = rsp_tdata[65:49];
            got.quad_last = rsp_tlast;
            if (projection_q.size() == 0) begin
               if (error_count < 10) $display("unexpected result beat %h", got);
               error_count <= error_count + 1;
            end else begin
               want = projection_q.pop_front();
               if (got !== want) begin
                  if (error_count < 10)
                     $display("mismatch: sx %h/%h sy %h/%h zd %b/%b dist %0d/%0d last %b/%b",
                              want.screen_x, got.screen_x, want.screen_y, got.screen_y,
                              want.zero_depth, got.zero_depth, want.quad_distance,
                              got.quad_distance, want.quad_last, got.quad_last);
                  error_count <= error_count + 1;
               end
            end
         end
         // vertex beats after the compare so a same-edge beat queues behind
         if (req_tvalid && req_tready) project_corner(req_tdata);
      end
      pending_count <= projection_q.size();
   end

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the quad vertex projection core
// Drives register settings and vertex quads with random idling on both
// channels; the checker predicts and compares the projected results.
// ----------------------------------------------------------------------------
`default_nettype none

module tb
   import qvp_pkg::*;
();

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [3:0]  csr_index = '0;
   logic [23:0] csr_data = '0;
   logic        req_tvalid = 0;
   logic        req_tready;
   logic [71:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 0;
   logic [71:0] rsp_tdata;
   logic        rsp_tlast;
   int          error_count, pending_count;
   int          send_idle = 0, recv_idle = 0;

   always begin
      #10 clock = 1;
      #10 clock = 0;
   end

   quad_vertex_projection_core u_top (.*);

   qvp_checker u_checker (.*);

   // sink stall
   always @(posedge clock) rsp_tready <= ($urandom_range(99) >= recv_idle);

   task automatic write_reg(logic [3:0] idx, logic [23:0] val);
      csr_index <= idx;
      csr_data <= val;
      csr_valid <= 1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 0;
      @(posedge clock);
   endtask

   // valid stays high between back-to-back beats; idling drops it
   task automatic send_vertex(logic [23:0] x, logic [23:0] y, logic [23:0] z);
      while ($urandom_range(99) < send_idle) begin
         req_tvalid <= 0;
         @(posedge clock);
      end
      req_tdata <= {z, y, x};
      req_tvalid <= 1;
      do @(posedge clock); while (!req_tready);
   endtask

   // wait for all results plus the block's own latency before a write
   task automatic drain();
      req_tvalid <= 0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(3))
         0: return 24'($urandom);
         1: return 24'($signed($urandom_range(8000)) - 4000);
         2: return $urandom_range(1) ? 24'h7FFFFF : 24'h800000;
         default: return 24'($signed($urandom_range(400000)) - 200000);
      endcase
   endfunction

   task automatic random_config(bit extreme);
      for (int r = 0; r < 8; r++) begin
         if (extreme) write_reg(4'(r), $urandom_range(1) ? 24'hFFFFFF : 24'h800000);
         else if (r == REG_YAW) write_reg(4'(r), 24'($urandom_range(65535)));
         else if (r == REG_FOCAL || r == REG_PX || r == REG_PY)
            write_reg(4'(r), $urandom_range(3) == 0 ? 24'($urandom) : 24'($urandom_range(200000)));
         else write_reg(4'(r), $urandom_range(3) == 0 ? 24'($urandom)
                                : 24'($signed($urandom_range(20000)) - 10000));
      end
      if ($urandom_range(1)) write_reg(4'd9, 24'($urandom));
   endtask

   initial begin
      #200_000_000;
      $display("quad_vertex_projection_core test failed");
      $finish;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: default settings, extremes, zero depth
      send_vertex(24'h000000, 24'h000000, 24'h000000);
      send_vertex(24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF);
      send_vertex(24'h800000, 24'h800000, 24'h800000);
      send_vertex(24'h000100, 24'hFFFF00, 24'h000A00);
      send_vertex(24'h001000, 24'h000100, 24'h000000);
      send_vertex(24'hFFF000, 24'h000200, 24'h001000);
      send_vertex(24'h7FFFFF, 24'h800000, 24'h000001);
      send_vertex(24'h800000, 24'h7FFFFF, 24'hFFFFFF);
      drain();
      // same yaw rewritten, then yaw at 0, 1/4, 1/2 and just under a full turn; camera moved mid-quad
      write_reg(REG_YAW, 24'd0);
      for (int q = 0; q < 4; q++) begin
         drain();
         write_reg(REG_YAW, 24'(q * 16384 + (q == 3 ? 16383 : 0)));
         send_vertex(24'h002000, 24'h000100, 24'h004000);
         send_vertex(24'hFFE000, 24'h000100, 24'h004000);
         drain();
         write_reg(REG_CAMX, 24'(q * 256));
         send_vertex(24'hFFE000, 24'hFFFF00, 24'h008000);
         send_vertex(24'h002000, 24'hFFFF00, 24'h008000);
      end
      drain();
      random_config(1);
      for (int k = 0; k < 4; k++) send_vertex(rand_coord(), rand_coord(), rand_coord());
      // random phases
      for (int ph = 0; ph < 3; ph++) begin
         send_idle = ph == 0 ? 32 : (ph == 1 ? 64 : 0);
         recv_idle = ph == 0 ? 64 : (ph == 1 ? 32 : 0);
         for (int s = 0; s < 4; s++) begin
            drain();
            random_config((ph == 2 && s == 3));
            for (int k = 0; k < 40; k++) send_vertex(rand_coord(), rand_coord(), rand_coord());
         end
      end
      drain();
      if (error_count == 0) begin
         $display("quad_vertex_projection_core test passed");
      end else begin
         $display("quad_vertex_projection_core test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire

// ===== sim.f =====
design/qvp_pkg.sv
design/quad_vertex_projection_core.sv
tb/qvp_checker.sv
tb/tb.sv
